// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the selective scan block.
// Included by files that carry concurrent checks; needs a clock named clk and reset rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define SSS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequence is checked in the following cycle.
`define SSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/sss_pkg.sv =====
// Shared types and constants of the selective state-space scan block.
// No dependencies; used by the top level and the testbench.
package sss_pkg;

  localparam int DATA_W            = 32;
  localparam int CHANNEL_W         = 7;
  localparam int SLOT_W            = 4;
  localparam int DEF_CHANNELS      = 128;
  localparam int DEF_STATE_SLOTS   = 16;
  localparam int DEF_FRACTION_BITS = 16;
  localparam int GROUP_SIZE        = 8;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_BC    = 2'd1,
    KIND_DECAY = 2'd2,
    KIND_SKIP  = 2'd3
  } kind_t;

endpackage

// ===== rtl/sss_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; instanced by the scan top level for the skip, decay and hidden-state tables.
module sss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/selective_state_space_scan_unit.sv =====
// Top level of the selective state-space scan: Q16.16 recurrence per channel and slot.
// Depends on sss_pkg, sss_ram and assert_macros.svh.
//
//   channel   handshake            payload
//   input     in_valid / in_ready  kind, channel, state_index, sequence_start, weights, x, dt
//   output    out_valid/out_ready  result_value, result_channel
//
// Every slot has its own lane; a data item passes six register stages and the output
// register before the result is offered. One item enters per cycle unless stalled or held.
// A data item waits while an earlier one of the same channel sits in the first three
// stages, as its hidden state is written back only at the end of stage three.
// A stalled output freezes the whole pipeline. Reset clears valid bits only; tables
// hold nothing defined until loaded.
`include "assert_macros.svh"

module selective_state_space_scan_unit
  import sss_pkg::*;
#(
  parameter int CHANNELS      = DEF_CHANNELS,
  parameter int STATE_SLOTS   = DEF_STATE_SLOTS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  kind,
  input  logic [CHANNEL_W-1:0]        channel,
  input  logic [SLOT_W-1:0]           state_index,
  input  logic                        sequence_start,
  input  logic signed [DATA_W-1:0]    input_sample,
  input  logic signed [DATA_W-1:0]    step_size,
  input  logic signed [DATA_W-1:0]    input_weight,
  input  logic signed [DATA_W-1:0]    output_weight,
  input  logic signed [DATA_W-1:0]    decay_rate,
  input  logic signed [DATA_W-1:0]    skip_gain,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [DATA_W-1:0]    result_value,
  output logic [CHANNEL_W-1:0]        result_channel
);

  localparam int AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW     = 2 * DATA_W;
  localparam int GROUPS = (STATE_SLOTS + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam logic [DATA_W-1:0] ONE = DATA_W'(1) << FRACTION_BITS;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic signed [PW-1:0]     prod_t;

  function automatic word_t qshift(input prod_t p);
    prod_t s;
    s = p >>> FRACTION_BITS;
    return word_t'(s[DATA_W-1:0]);
  endfunction

  logic adv;
  logic accept;
  logic hazard;
  logic ch_ok;
  logic is_data;
  logic [AW-1:0] in_addr;

  // Current time step's B and C vectors.
  word_t b_weight [STATE_SLOTS];
  word_t c_weight [STATE_SLOTS];

  // Stage registers.
  logic                 s1_v, s2_v, s3_v, s4_v, s5_v, s6_v;
  logic [CHANNEL_W-1:0] s1_ch, s2_ch, s3_ch, s4_ch, s5_ch, s6_ch;
  logic                 s1_start;
  word_t                s1_x, s1_dt, s2_x;
  word_t                s1_b [STATE_SLOTS];
  word_t                s1_c [STATE_SLOTS];
  word_t                s2_c [STATE_SLOTS];
  word_t                s3_c [STATE_SLOTS];
  word_t                s4_c [STATE_SLOTS];
  word_t                a_rd [STATE_SLOTS];
  word_t                h_rd [STATE_SLOTS];
  word_t                d_rd;
  prod_t                s2_pa [STATE_SLOTS];
  prod_t                s2_pb [STATE_SLOTS];
  word_t                s2_hold [STATE_SLOTS];
  word_t                da [STATE_SLOTS];
  prod_t                s2_skip;
  prod_t                s3_qa [STATE_SLOTS];
  prod_t                s3_qb [STATE_SLOTS];
  word_t                s3_skip, s4_skip, s5_skip, s6_skip;
  word_t                h_new [STATE_SLOTS];
  word_t                s4_h [STATE_SLOTS];
  prod_t                s5_qc [STATE_SLOTS];
  word_t                gsum_next [GROUPS];
  word_t                s6_gsum [GROUPS];
  word_t                total;

  assign adv      = !out_valid || out_ready;
  assign is_data  = (kind_t'(kind) == KIND_DATA);
  assign ch_ok    = (32'(channel) < CHANNELS);
  assign in_addr  = AW'(channel);
  assign hazard   = is_data &&
                    ((s1_v && s1_ch == channel) || (s2_v && s2_ch == channel) ||
                     (s3_v && s3_ch == channel));
  assign in_ready = adv && !hazard;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (accept && kind_t'(kind) == KIND_BC) begin
      for (int n = 0; n < STATE_SLOTS; n++) begin
        if (32'(state_index) == n) begin
          b_weight[n] <= input_weight;
          c_weight[n] <= output_weight;
        end
      end
    end
  end

  sss_ram #(.WIDTH(DATA_W), .DEPTH(CHANNELS), .AW(AW)) u_skip_ram (
    .clk   (clk),
    .we    (accept && kind_t'(kind) == KIND_SKIP && ch_ok),
    .waddr (in_addr),
    .wdata (skip_gain),
    .re    (accept && is_data),
    .raddr (in_addr),
    .rdata (d_rd)
  );

  for (genvar n = 0; n < STATE_SLOTS; n++) begin : g_lane
    sss_ram #(.WIDTH(DATA_W), .DEPTH(CHANNELS), .AW(AW)) u_decay_ram (
      .clk   (clk),
      .we    (accept && kind_t'(kind) == KIND_DECAY && ch_ok && 32'(state_index) == n),
      .waddr (in_addr),
      .wdata (decay_rate),
      .re    (accept && is_data),
      .raddr (in_addr),
      .rdata (a_rd[n])
    );

    sss_ram #(.WIDTH(DATA_W), .DEPTH(CHANNELS), .AW(AW)) u_hidden_ram (
      .clk   (clk),
      .we    (adv && s3_v),
      .waddr (AW'(s3_ch)),
      .wdata (h_new[n]),
      .re    (accept && is_data),
      .raddr (in_addr),
      .rdata (h_rd[n])
    );

    // The decay factor wraps to 32 bits before it is multiplied.
    assign da[n]    = word_t'(ONE) + qshift(s2_pa[n]);
    assign h_new[n] = qshift(s3_qa[n]) + qshift(s3_qb[n]);

    always_ff @(posedge clk) begin
      if (adv) begin
        if (accept) begin
          s1_b[n] <= b_weight[n];
          s1_c[n] <= c_weight[n];
        end
        s2_pa[n]   <= prod_t'(s1_dt) * prod_t'(a_rd[n]);
        s2_pb[n]   <= prod_t'(s1_dt) * prod_t'(s1_b[n]);
        s2_hold[n] <= s1_start ? '0 : h_rd[n];
        s2_c[n]    <= s1_c[n];
        s3_qa[n]   <= prod_t'(da[n]) * prod_t'(s2_hold[n]);
        s3_qb[n]   <= prod_t'(qshift(s2_pb[n])) * prod_t'(s2_x);
        s3_c[n]    <= s2_c[n];
        s4_h[n]    <= h_new[n];
        s4_c[n]    <= s3_c[n];
        s5_qc[n]   <= prod_t'(s4_c[n]) * prod_t'(s4_h[n]);
      end
    end
  end

  // First level of the lane sum: groups of eight lanes.
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      gsum_next[g] = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (g * GROUP_SIZE + k < STATE_SLOTS) begin
          gsum_next[g] = gsum_next[g] + qshift(s5_qc[g * GROUP_SIZE + k]);
        end
      end
    end
  end

  always_comb begin
    total = s6_skip;
    for (int g = 0; g < GROUPS; g++) begin
      total = total + s6_gsum[g];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (accept) begin
        s1_ch    <= channel;
        s1_start <= sequence_start;
        s1_x     <= input_sample;
        s1_dt    <= step_size;
      end
      s2_ch   <= s1_ch;
      s2_x    <= s1_x;
      s2_skip <= prod_t'(d_rd) * prod_t'(s1_x);
      s3_ch   <= s2_ch;
      s3_skip <= qshift(s2_skip);
      s4_ch   <= s3_ch;
      s4_skip <= s3_skip;
      s5_ch   <= s4_ch;
      s5_skip <= s4_skip;
      s6_ch   <= s5_ch;
      s6_skip <= s5_skip;
      s6_gsum <= gsum_next;
      result_channel <= s6_ch;
      result_value   <= total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      s6_v <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_v <= accept && is_data && ch_ok;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= s4_v;
      s6_v <= s5_v;
      out_valid <= s6_v;
    end
  end

  // A hidden-state write must never meet a read of the same channel in one cycle.
  `SSS_ASSERT_IMPL(a_no_rmw_overlap, accept && is_data && s3_v, s3_ch != channel)
  `SSS_ASSERT_NEXT(a_data_enters, accept && is_data && ch_ok, s1_v)
  `SSS_ASSERT_IMPL(a_result_source, $rose(out_valid), $past(s6_v))
  `SSS_ASSERT_IMPL(a_stall_freezes, !adv && s3_v, !in_ready)

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for selective_state_space_scan_unit.
// Depends on sss_pkg; predicts each data result in-line and checks outputs in order.
module tb_top;
  import sss_pkg::*;

  localparam int NCH    = 128;
  localparam int NSLOT  = 16;
  localparam int FRAC   = 16;
  localparam int DRAIN  = 20;
  localparam int WD_MAX = 4000;
  localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC;

  typedef struct {
    kind_t             kind;
    logic [6:0]        ch;
    logic [3:0]        slot;
    logic              start;
    logic signed [31:0] x, dt, b, c, a, d;
  } scan_item_t;

  typedef struct {
    logic signed [31:0] value;
    logic [6:0]         ch;
  } scan_result_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic [1:0] kind = 0;
  logic [6:0] channel = 0;
  logic [3:0] state_index = 0;
  logic sequence_start = 0;
  logic signed [31:0] input_sample = 0, step_size = 0, input_weight = 0;
  logic signed [31:0] output_weight = 0, decay_rate = 0, skip_gain = 0;
  logic signed [31:0] result_value;
  logic [6:0] result_channel;

  selective_state_space_scan_unit u_top (.*);

  // Predictor state.
  logic signed [31:0] hid [NCH*NSLOT];
  logic signed [31:0] decay [NCH*NSLOT];
  logic signed [31:0] skip_tab [NCH];
  logic signed [31:0] bvec [NSLOT], cvec [NSLOT];
  bit hid_ok [NCH];
  bit chan_ready [NCH];
  int ready_list [$];

  scan_result_t y_pending [$];
  int errors = 0;
  int burst_left = 0;
  bit hold_req = 0;
  int idle_cycles = 0;

  initial forever #4 clk = ~clk;

  function automatic logic signed [31:0] qmul(logic signed [31:0] p, logic signed [31:0] q);
    logic signed [63:0] prod;
    prod = p * q;
    return prod[47:16];
  endfunction

  // Applies one accepted transfer to the predictor and queues any expected result.
  function automatic void predict_scan(scan_item_t it);
    logic signed [31:0] acc, da, db, old, h;
    int idx;
    acc = 0;
    case (it.kind)
      KIND_BC: begin
        bvec[it.slot] = it.b;
        cvec[it.slot] = it.c;
      end
      KIND_DECAY: decay[it.ch*NSLOT + it.slot] = it.a;
      KIND_SKIP: skip_tab[it.ch] = it.d;
      default: begin
        for (int n = 0; n < NSLOT; n++) begin
          idx = it.ch*NSLOT + n;
          da = ONE_Q + qmul(it.dt, decay[idx]);
          db = qmul(it.dt, bvec[n]);
          old = it.start ? 32'sd0 : hid[idx];
          h = qmul(da, old) + qmul(db, it.x);
          hid[idx] = h;
          acc = acc + qmul(cvec[n], h);
        end
        acc = acc + qmul(skip_tab[it.ch], it.x);
        hid_ok[it.ch] = 1;
        y_pending.push_back('{acc, it.ch});
      end
    endcase
  endfunction

  // Q16.16 value: mostly modest magnitudes, sometimes extremes or full range.
  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: return $urandom;
      default: return $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
    endcase
  endfunction

  function automatic scan_item_t noise_item(kind_t k);
    scan_item_t it;
    it.kind = k;
    it.ch = 7'($urandom);
    it.slot = 4'($urandom);
    it.start = 1'($urandom);
    it.x = $urandom; it.dt = $urandom; it.b = $urandom;
    it.c = $urandom; it.a = $urandom; it.d = $urandom;
    return it;
  endfunction

  task automatic send_item(scan_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    kind <= it.kind;
    channel <= it.ch;
    state_index <= it.slot;
    sequence_start <= it.start;
    input_sample <= it.x;
    step_size <= it.dt;
    input_weight <= it.b;
    output_weight <= it.c;
    decay_rate <= it.a;
    skip_gain <= it.d;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_scan(it);
    burst_left--;
  endtask

  task automatic load_bc(int slot, logic signed [31:0] b, logic signed [31:0] c);
    scan_item_t it;
    it = noise_item(KIND_BC);
    it.slot = 4'(slot); it.b = b; it.c = c;
    send_item(it);
  endtask

  task automatic load_channel(int ch);
    scan_item_t it;
    for (int n = 0; n < NSLOT; n++) begin
      it = noise_item(KIND_DECAY);
      it.ch = 7'(ch); it.slot = 4'(n);
      it.a = -$signed(32'($urandom_range(0, 32'h20000)));
      if ($urandom_range(0, 7) == 0) it.a = rand_q();
      send_item(it);
    end
    it = noise_item(KIND_SKIP);
    it.ch = 7'(ch); it.d = rand_q();
    send_item(it);
    if (!chan_ready[ch]) ready_list.push_back(ch);
    chan_ready[ch] = 1;
  endtask

  task automatic send_data(int ch, logic signed [31:0] x, logic signed [31:0] dt, bit start);
    scan_item_t it;
    it = noise_item(KIND_DATA);
    it.ch = 7'(ch); it.x = x; it.dt = dt;
    it.start = start || !hid_ok[ch];
    send_item(it);
  endtask

  task automatic test_directed();
    for (int n = 0; n < NSLOT; n++)
      load_bc(n, n[0] ? 32'sh7fffffff : 32'sh80000000, n[1] ? ONE_Q : -ONE_Q);
    load_channel(0);
    load_channel(127);
    send_data(0, 32'sh7fffffff, 32'sh7fffffff, 1);
    send_data(0, 32'sh80000000, 32'sh80000000, 0);
    send_data(127, 32'sd0, ONE_Q, 1);
    send_data(127, ONE_Q, 32'sd0, 0);
    send_data(127, -ONE_Q, 32'sh80000000, 0);
    send_data(0, ONE_Q, ONE_Q >>> 4, 1);
    // Same channel back to back exercises the state write-back hazard.
    send_data(0, 32'sh00020000, ONE_Q >>> 3, 0);
    send_data(0, 32'sh7fffffff, 32'sh7fffffff, 0);
  endtask

  task automatic test_random_steps(int n_items);
    int sent, ch, pick;
    scan_item_t it;
    sent = 0;
    while (sent < n_items) begin
      // A new time step: refresh none, some or all of B and C.
      pick = $urandom_range(0, 3) == 0 ? NSLOT : $urandom_range(0, 4);
      for (int k = 0; k < pick; k++) begin
        load_bc(pick == NSLOT ? k : $urandom_range(0, NSLOT-1), rand_q(), rand_q());
        sent++;
      end
      if ($urandom_range(0, 9) == 0 && ready_list.size() < 24) begin
        load_channel($urandom_range(0, NCH-1));
        sent += NSLOT + 1;
      end
      if ($urandom_range(0, 5) == 0) begin
        it = noise_item($urandom_range(0, 1) ? KIND_DECAY : KIND_SKIP);
        it.ch = 7'(ready_list[$urandom_range(0, ready_list.size()-1)]);
        send_item(it);
        sent++;
      end
      repeat ($urandom_range(2, 12)) begin
        ch = ready_list[$urandom_range(0, ready_list.size()-1)];
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(2, 4) : 1) begin
          send_data(ch, rand_q(), $urandom_range(0, 4) == 0 ? rand_q()
                    : $signed($urandom_range(0, 32'h8000)), $urandom_range(0, 9) == 0);
          sent++;
        end
      end
    end
  endtask

  task automatic test_backpressure();
    hold_req = 1;
    burst_left = 200;
    repeat (60) send_data(ready_list[$urandom_range(0, ready_list.size()-1)],
                          rand_q(), rand_q(), 0);
  endtask

  // Receiver: ready pattern is redrawn at random from three modes, plus one long hold-off on request.
  initial begin
    int mode, cnt;
    cnt = 0; mode = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_ready <= 0;
        repeat (300) @(posedge clk);
      end else begin
        if (cnt % 64 == 0) mode = $urandom_range(0, 2);
        cnt++;
        case (mode)
          0: out_ready <= 1;
          1: out_ready <= $urandom_range(0, 1);
          default: out_ready <= $urandom_range(0, 9) != 0;
        endcase
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    scan_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (y_pending.size() == 0) begin
        $display("%0t: result with none expected: value %h channel %0d",
                 $time, result_value, result_channel);
        errors++;
      end else begin
        e = y_pending.pop_front();
        if (result_value !== e.value) begin
          $display("%0t: result_value expected %h actual %h", $time, e.value, result_value);
          errors++;
        end
        if (result_channel !== e.ch) begin
          $display("%0t: result_channel expected %0d actual %0d", $time, e.ch, result_channel);
          errors++;
        end
      end
    end
  end

  // Watchdog: counts cycles with work pending but no transfer on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (!in_valid && y_pending.size() == 0))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_MAX) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_random_steps(530);
    test_backpressure();
    in_valid <= 0;
    while (y_pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && y_pending.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== selective_state_space_scan_unit.f =====
+incdir+rtl
rtl/sss_pkg.sv
rtl/sss_ram.sv
rtl/selective_state_space_scan_unit.sv
bench/tb_top.sv
